// ===== sv/keyword_lexer_unit_macros.svh =====
// Assertion macros shared by the keyword lexer modules.
`ifndef KEYWORD_LEXER_UNIT_MACROS_SVH
`define KEYWORD_LEXER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define KLEX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define KLEX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/klex_pkg.sv =====
// Types, constants and helper functions of the keyword lexer.
package klex_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int LINE_WIDTH   = 16;
   localparam int KW_COUNT     = 10;
   localparam int KW_MAX_LEN   = 6;
   localparam int KW_IDX_W     = 4;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] WORD_LEN_MAX = 8'hFF;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00},
      '{"s", "t", "a", "t", "i", "c"},
      '{"b", "o", "o", "l", 8'h00, 8'h00},
      '{"c", "o", "n", "s", "t", 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"a", "u", "t", "o", 8'h00, 8'h00}
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd3, 8'd5, 8'd4, 8'd6, 8'd4, 8'd5, 8'd5, 8'd2, 8'd4
   };

   typedef enum logic [1:0] {
      KIND_KEYWORD = 2'd0,
      KIND_IDENT   = 2'd1,
      KIND_NUMBER  = 2'd2,
      KIND_SPECIAL = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NUM  = 2'd1,
      MODE_WORD = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
   } req_type;

   typedef struct packed {
      kind_type                  kind;
      logic [KW_IDX_W-1:0]       keyword_index;
      logic [NUMBER_WIDTH-1:0]   number_value;
      logic                      number_saturated;
      logic [7:0]                special_char;
      logic [7:0]                word_length;
      logic [LINE_WIDTH-1:0]     line_number;
      logic                      last_of_run;
   } rsp_type;

   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type result0;
      rsp_type result1;
   } push_type;

   typedef struct packed {
      logic                hit;
      logic [KW_IDX_W-1:0] index;
   } match_type;

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] value;
      logic                    ovf;
   } accum_type;

   typedef logic [KW_MAX_LEN-1:0][7:0] prefix_type;

   function automatic match_type klex_match(input prefix_type chars, input logic [7:0] len);
      match_type m;
      logic      eq;
      m = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         eq = (len == KW_LEN[k]);
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if ((8'(j) < KW_LEN[k]) && (chars[j] != KW_TEXT[k][j])) eq = 1'b0;
         end
         if (eq) begin
            m.hit   = 1'b1;
            m.index = KW_IDX_W'(k);
         end
      end
      return m;
   endfunction

   function automatic accum_type klex_add_digit(input logic [NUMBER_WIDTH-1:0] acc,
                                                input logic [3:0] d);
      accum_type             r;
      logic [NUMBER_WIDTH+3:0] wide;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUMBER_WIDTH+4)'(d);
      r.ovf   = (wide[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'b0);
      r.value = r.ovf ? '1 : wide[NUMBER_WIDTH-1:0];
      return r;
   endfunction

   function automatic rsp_type klex_number_rsp(input logic [NUMBER_WIDTH-1:0] value,
                                               input logic sat,
                                               input logic [LINE_WIDTH-1:0] line);
      rsp_type r;
      r = '0;
      r.kind             = KIND_NUMBER;
      r.number_value     = value;
      r.number_saturated = sat;
      r.line_number      = line;
      return r;
   endfunction

   function automatic rsp_type klex_word_rsp(input prefix_type chars, input logic [7:0] len,
                                             input logic [LINE_WIDTH-1:0] line);
      rsp_type   r;
      match_type m;
      m = klex_match(chars, len);
      r = '0;
      r.kind          = m.hit ? KIND_KEYWORD : KIND_IDENT;
      r.keyword_index = m.hit ? m.index : '0;
      r.word_length   = len;
      r.line_number   = line;
      return r;
   endfunction

endpackage

// ===== sv/keyword_lexer_unit.sv =====
// Keyword lexer top level: byte stream in, token stream out.
//
// req channel carries one source byte (char_in) and a last flag per transfer.
// rsp channel carries one token per transfer: keyword, identifier, number
// (saturating) or special character, with the line count before the token.
// Bytes are taken at one per cycle while the result queue has room. A byte
// enters an input register, is classified in the following cycle and its zero,
// one or two tokens land in a four-entry result queue; the first token passes
// the input register and then the queue before it is offered on the result
// port. The result port gives one token per cycle while the receiver is ready,
// so a byte that makes two tokens needs two output transfers.
// The input register advances only while the queue has two free entries;
// when the receiver stalls, results are held in the queue and req_ready
// drops once the queue nears full. No token is lost or repeated.
// Reset empties the queue and the input register, closes any open token and
// clears the line count. A transfer with last set emits any open word or
// number after its own byte and starts the next byte with no open token.
module keyword_lexer_unit #(
   parameter int WORD_BUF_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  klex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output klex_pkg::rsp_type rsp_data
);

   klex_pkg::push_type push;
   logic               room;

   klex_scan #(
      .WORD_BUF_DEPTH(WORD_BUF_DEPTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .room     (room),
      .push     (push)
   );

   klex_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sv/klex_scan.sv =====
// Input register, scanner state and token classification of the keyword lexer.
`include "keyword_lexer_unit_macros.svh"

module klex_scan #(
   parameter int WORD_BUF_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  klex_pkg::req_type  req_data,
   input  logic               room,
   output klex_pkg::push_type push
);

   localparam int IDX_W = $clog2(WORD_BUF_DEPTH);

   logic                                 in_valid_ff, in_valid_in;
   klex_pkg::req_type                    in_ff, in_in;
   klex_pkg::mode_type                   mode_ff, mode_in, mode_mid;
   logic [klex_pkg::NUMBER_WIDTH-1:0]    accum_ff, accum_in;
   logic                                 ovf_ff, ovf_in;
   logic [7:0]                           len_ff, len_in;
   logic [klex_pkg::LINE_WIDTH-1:0]      line_ff, line_in;
   logic [7:0]                           chars_ff [WORD_BUF_DEPTH];
   logic [7:0]                           chars_in [WORD_BUF_DEPTH];

   logic                    advance;
   logic [7:0]              c;
   logic                    is_digit, is_alpha, is_space, cont;
   logic                    close_v, special_v, flush_v, second_v;
   logic [7:0]              base_len, post_len;
   logic                    base_ovf;
   logic [klex_pkg::NUMBER_WIDTH-1:0] base_accum;
   klex_pkg::accum_type     added;
   logic [7:0]              post_chars [WORD_BUF_DEPTH];
   klex_pkg::prefix_type    old_prefix, post_prefix;
   klex_pkg::rsp_type       close_rsp, second_rsp;

   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      c        = in_ff.char_in;
      is_digit = (c >= klex_pkg::CHAR_ZERO) && (c <= klex_pkg::CHAR_NINE);
      is_alpha = ((c >= klex_pkg::CHAR_UP_A) && (c <= klex_pkg::CHAR_UP_Z)) ||
                 ((c >= klex_pkg::CHAR_LO_A) && (c <= klex_pkg::CHAR_LO_Z));
      is_space = (c == klex_pkg::CHAR_SPACE) ||
                 ((c >= klex_pkg::CHAR_TAB) && (c <= klex_pkg::CHAR_CR));
      cont     = ((mode_ff == klex_pkg::MODE_NUM) && is_digit) ||
                 ((mode_ff == klex_pkg::MODE_WORD) && (is_alpha || is_digit));
      close_v  = (mode_ff != klex_pkg::MODE_IDLE) && !cont;

      if (cont) mode_mid = mode_ff;
      else if (is_digit) mode_mid = klex_pkg::MODE_NUM;
      else if (is_alpha) mode_mid = klex_pkg::MODE_WORD;
      else mode_mid = klex_pkg::MODE_IDLE;

      base_accum = cont ? accum_ff : '0;
      base_ovf   = cont ? ovf_ff : 1'b0;
      added      = klex_pkg::klex_add_digit(base_accum, 4'(c - klex_pkg::CHAR_ZERO));
      added.ovf  = added.ovf | base_ovf;

      base_len   = cont ? len_ff : 8'd0;
      post_len   = (base_len < klex_pkg::WORD_LEN_MAX) ? base_len + 8'd1 : base_len;
      post_chars = chars_ff;
      if (base_len < 8'(WORD_BUF_DEPTH)) post_chars[base_len[IDX_W-1:0]] = c;

      for (int j = 0; j < klex_pkg::KW_MAX_LEN; j++) begin
         old_prefix[j]  = chars_ff[j];
         post_prefix[j] = post_chars[j];
      end

      special_v = !cont && !is_digit && !is_alpha && !is_space;
      flush_v   = in_ff.last && (mode_mid != klex_pkg::MODE_IDLE);
      second_v  = special_v || flush_v;

      if (mode_ff == klex_pkg::MODE_NUM)
         close_rsp = klex_pkg::klex_number_rsp(accum_ff, ovf_ff, line_ff);
      else
         close_rsp = klex_pkg::klex_word_rsp(old_prefix, len_ff, line_ff);

      if (special_v) begin
         second_rsp              = '0;
         second_rsp.kind         = klex_pkg::KIND_SPECIAL;
         second_rsp.special_char = c;
         second_rsp.line_number  = line_ff;
      end else if (mode_mid == klex_pkg::MODE_NUM) begin
         second_rsp = klex_pkg::klex_number_rsp(added.value, added.ovf, line_ff);
      end else begin
         second_rsp = klex_pkg::klex_word_rsp(post_prefix, post_len, line_ff);
      end
      close_rsp.last_of_run  = !second_v;
      second_rsp.last_of_run = 1'b1;

      push.valid0  = advance && (close_v || second_v);
      push.valid1  = advance && close_v && second_v;
      push.result0 = close_v ? close_rsp : second_rsp;
      push.result1 = second_rsp;

      in_valid_in = req_ready ? req_valid : in_valid_ff;
      in_in       = (req_valid && req_ready) ? req_data : in_ff;
      mode_in     = mode_ff;
      accum_in    = accum_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      line_in     = line_ff;
      chars_in    = chars_ff;
      if (advance) begin
         mode_in = in_ff.last ? klex_pkg::MODE_IDLE : mode_mid;
         if (mode_mid == klex_pkg::MODE_NUM) begin
            accum_in = added.value;
            ovf_in   = added.ovf;
         end
         if (mode_mid == klex_pkg::MODE_WORD) begin
            len_in   = post_len;
            chars_in = post_chars;
         end
         if (c == klex_pkg::CHAR_LF) line_in = line_ff + klex_pkg::LINE_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= klex_pkg::MODE_IDLE;
         accum_ff    <= '0;
         ovf_ff      <= 1'b0;
         len_ff      <= 8'd0;
         line_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         accum_ff    <= accum_in;
         ovf_ff      <= ovf_in;
         len_ff      <= len_in;
         line_ff     <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      chars_ff <= chars_in;
   end

   `KLEX_ASSERT_SAME(a_pair_compact, clock, reset, push.valid1, push.valid0, "second result without first")
   `KLEX_ASSERT_SAME(a_push_needs_room, clock, reset, push.valid0, room && in_valid_ff, "push without room")
   `KLEX_ASSERT_SAME(a_keyword_index, clock, reset, push.valid0 && (push.result0.kind == klex_pkg::KIND_KEYWORD), push.result0.keyword_index <= klex_pkg::KW_IDX_W'(klex_pkg::KW_COUNT - 1), "keyword index out of table")

endmodule

// ===== sv/klex_queue.sv =====
// Result queue of the keyword lexer: takes up to two results a cycle, gives one while the receiver is ready.
`include "keyword_lexer_unit_macros.svh"

module klex_queue (
   input  logic               clock,
   input  logic               reset,
   input  klex_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output klex_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   klex_pkg::rsp_type  q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         n_push;
   logic               pop;

   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = {1'b0, push.valid0} + {1'b0, push.valid1};

   always_comb begin
      wr_in    = wr_ff + PTR_W'(n_push);
      rd_in    = rd_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) q_ff[wr_ff] <= push.result0;
      if (push.valid1) q_ff[wr_ff + PTR_W'(1)] <= push.result1;
   end

   `KLEX_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `KLEX_ASSERT_NEXT(a_push_shows, clock, reset, push.valid0, rsp_valid, "pushed result not visible")
   `KLEX_ASSERT_NEXT(a_count_track, clock, reset, !push.valid0 && !pop, count_ff == $past(count_ff), "count moved while idle")

endmodule
